>>> rtl/core/stl_pkg.sv
`timescale 1ns / 1ps
// Shared codes, character classes, keyword tables and result type for the source token lexer.
package stl_pkg;

   localparam int POS_W  = 16;
   localparam int LEN_W  = 8;
   localparam int KIND_W = 5;
   localparam int MODE_W = 3;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // lexer modes
   localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_IDENT   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_NUMBER  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STRING  = 3'd3;
   localparam logic [MODE_W-1:0] MODE_ESCAPE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_OPER    = 3'd5;
   localparam logic [MODE_W-1:0] MODE_COMMENT = 3'd6;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_EOF       = 5'd0;
   localparam logic [KIND_W-1:0] KIND_KW_BASE   = 5'd1;
   localparam logic [KIND_W-1:0] KIND_IDENT     = 5'd8;
   localparam logic [KIND_W-1:0] KIND_NUMBER    = 5'd9;
   localparam logic [KIND_W-1:0] KIND_STRING    = 5'd10;
   localparam logic [KIND_W-1:0] KIND_OP_ASSIGN = 5'd11;
   localparam logic [KIND_W-1:0] KIND_OP_ARROW  = 5'd12;
   localparam logic [KIND_W-1:0] KIND_OP_PLUS   = 5'd13;
   localparam logic [KIND_W-1:0] KIND_OP_MINUS  = 5'd14;
   localparam logic [KIND_W-1:0] KIND_OP_STAR   = 5'd15;
   localparam logic [KIND_W-1:0] KIND_OP_SLASH  = 5'd16;
   localparam logic [KIND_W-1:0] KIND_OP_EQ     = 5'd17;
   localparam logic [KIND_W-1:0] KIND_OP_GT     = 5'd18;
   localparam logic [KIND_W-1:0] KIND_OP_LT     = 5'd19;
   localparam logic [KIND_W-1:0] KIND_OP_LE     = 5'd20;
   localparam logic [KIND_W-1:0] KIND_COMMA     = 5'd21;
   localparam logic [KIND_W-1:0] KIND_SEMI      = 5'd22;
   localparam logic [KIND_W-1:0] KIND_LPAREN    = 5'd23;
   localparam logic [KIND_W-1:0] KIND_RPAREN    = 5'd24;
   localparam logic [KIND_W-1:0] KIND_LBRACK    = 5'd25;
   localparam logic [KIND_W-1:0] KIND_RBRACK    = 5'd26;
   localparam logic [KIND_W-1:0] KIND_LBRACE    = 5'd27;
   localparam logic [KIND_W-1:0] KIND_RBRACE    = 5'd28;
   localparam logic [KIND_W-1:0] KIND_COMMENT   = 5'd29;
   localparam logic [KIND_W-1:0] KIND_ILLEGAL   = 5'd30;
   localparam logic [KIND_W-1:0] KIND_OP_GE     = 5'd31;

   // characters with a role of their own
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   localparam int NUM_KW = 7;

   localparam logic [7:0] KW_TEXT [NUM_KW][8] = '{
      '{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"f", "n", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"m", "a", "t", "c", "h", 8'h00, 8'h00, 8'h00},
      '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
      '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [LEN_W-1:0] KW_LEN [NUM_KW] = '{
      8'd3, 8'd2, 8'd5, 8'd4, 8'd6, 8'd5, 8'd3
   };

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  line;
      logic [POS_W-1:0]  column;
      logic [POS_W-1:0]  offset;
      logic [LEN_W-1:0]  length;
      logic              last;
   } rsp_type;

   function automatic logic is_alpha(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return b == " " || (b >= 8'd9 && b <= 8'd13);
   endfunction

   function automatic logic is_punct(input logic [7:0] b);
      return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
             (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
   endfunction

   function automatic logic is_oper_start(input logic [7:0] b);
      return b == ":" || b == "+" || b == "-" || b == "/" ||
             b == "=" || b == ">" || b == "<" || b == "*";
   endfunction

   // keywords whose character at pos equals b
   function automatic logic [NUM_KW-1:0] kw_match(input logic [7:0] b,
                                                 input logic [LEN_W-1:0] pos);
      logic [NUM_KW-1:0] m;
      m = '0;
      for (int i = 0; i < NUM_KW; i++) begin
         m[i] = (pos < KW_LEN[i]) && (KW_TEXT[i][pos[2:0]] == b);
      end
      return m;
   endfunction

   function automatic logic [KIND_W-1:0] oper_kind(input logic [LEN_W-1:0] run,
                                                  input logic [7:0] a,
                                                  input logic [7:0] c);
      logic [KIND_W-1:0] k;
      k = KIND_ILLEGAL;
      if (run == 8'd1) begin
         case (a)
            "+":     k = KIND_OP_PLUS;
            "-":     k = KIND_OP_MINUS;
            "*":     k = KIND_OP_STAR;
            "/":     k = KIND_OP_SLASH;
            "=":     k = KIND_OP_EQ;
            ">":     k = KIND_OP_GT;
            "<":     k = KIND_OP_LT;
            default: k = KIND_ILLEGAL;
         endcase
      end else if (run == 8'd2) begin
         if (a == ":" && c == "=") k = KIND_OP_ASSIGN;
         else if (a == "-" && c == ">") k = KIND_OP_ARROW;
         else if (a == "<" && c == "=") k = KIND_OP_LE;
         else if (a == ">" && c == "=") k = KIND_OP_GE;
      end
      return k;
   endfunction

   // single-byte token at a token start: brackets and separators, else illegal
   function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] b);
      logic [KIND_W-1:0] k;
      case (b)
         ",":     k = KIND_COMMA;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "[":     k = KIND_LBRACK;
         "]":     k = KIND_RBRACK;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         default: k = KIND_ILLEGAL;
      endcase
      return k;
   endfunction

endpackage

>>> rtl/core/source_token_lexer.sv
`timescale 1ns / 1ps
// Source token lexer: byte stream in, tokens with start positions and lengths out.
// One source byte is taken per cycle, unless the input stalls, into an input register;
// once the queue has room it is classified against the current lexer mode and gives zero,
// one or two tokens for a four-entry result queue, so a byte that ends a token and starts
// a single-byte one gives two items. The input stalls only while the queue holds more than
// two items, so with the result side draining one item per cycle the sustained rate is one
// byte per cycle, bounded by the single read port of the result queue when bytes give two
// tokens each. A zero byte or the end mark flushes the pending token and emits end-of-file;
// every later byte gives one more end-of-file until reset. Positions saturate at
// min(2^POS_BITS-1, 65535), lengths at min(MAX_TOKEN_LEN, 255).
module source_token_lexer
   import stl_pkg::*;
#(
   parameter int MAX_TOKEN_LEN = 255,
   parameter int POS_BITS      = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_char_byte,
   input  logic              req_at_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_token_kind,
   output logic [POS_W-1:0]  rsp_start_line,
   output logic [POS_W-1:0]  rsp_start_column,
   output logic [POS_W-1:0]  rsp_start_offset,
   output logic [LEN_W-1:0]  rsp_token_length,
   output logic              rsp_last_result
);

   localparam int POS_CAP = (POS_BITS >= POS_W) ? 65535 : (1 << POS_BITS) - 1;
   localparam int LEN_CAP = (MAX_TOKEN_LEN > 255) ? 255 : MAX_TOKEN_LEN;
   localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(POS_CAP);
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LEN_CAP);

   function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] x);
      return (x < POS_LIMIT) ? x + 1'b1 : POS_LIMIT;
   endfunction

   function automatic logic [LEN_W-1:0] len_inc(input logic [LEN_W-1:0] x);
      return (x < LEN_LIMIT) ? x + 1'b1 : LEN_LIMIT;
   endfunction

   // input register
   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff, in_byte_in;
   logic        in_end_ff, in_end_in;

   // lexer state
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [LEN_W-1:0]  run_ff, run_in;
   logic [POS_W-1:0]  tok_line_ff, tok_line_in;
   logic [POS_W-1:0]  tok_col_ff, tok_col_in;
   logic [POS_W-1:0]  tok_off_ff, tok_off_in;
   logic [POS_W-1:0]  line_ff, line_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [POS_W-1:0]  byte_ff, byte_in;
   logic [NUM_KW-1:0] kw_ff, kw_in;
   logic              dot_ff, dot_in;
   logic [7:0]        opa_ff, opa_in;
   logic [7:0]        opc_ff, opc_in;
   logic              finished_ff, finished_in;

   // result queue
   rsp_type              fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;

   logic       accept, fire, pop;
   logic       r0_v, r1_v;
   rsp_type    r0, r1, wr_a;
   logic [1:0] n_push;

   logic              is_end, brk, start;
   logic [7:0]        b;
   logic [POS_W-1:0]  line_n, col_n;
   logic [KIND_W-1:0] flush_kind;
   logic              flush_live;

   assign fire      = in_valid_ff && (count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH - 2));
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_end_in   = in_end_ff;
      if (accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_char_byte;
         in_end_in   = req_at_end;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // kind of the pending token, should it end now
   always_comb begin
      flush_live = 1'b1;
      flush_kind = KIND_ILLEGAL;
      case (mode_ff)
         MODE_IDENT: begin
            flush_kind = KIND_IDENT;
            for (int i = NUM_KW - 1; i >= 0; i--) begin
               if (kw_ff[i] && run_ff == KW_LEN[i]) flush_kind = KIND_KW_BASE + KIND_W'(i);
            end
         end
         MODE_NUMBER:  flush_kind = KIND_NUMBER;
         MODE_STRING:  flush_kind = KIND_ILLEGAL;
         MODE_ESCAPE:  flush_kind = KIND_ILLEGAL;
         MODE_OPER:    flush_kind = oper_kind(run_ff, opa_ff, opc_ff);
         MODE_COMMENT: flush_kind = KIND_COMMENT;
         default:      flush_live = 1'b0;
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      run_in      = run_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      tok_off_in  = tok_off_ff;
      line_in     = line_ff;
      col_in      = col_ff;
      byte_in     = byte_ff;
      kw_in       = kw_ff;
      dot_in      = dot_ff;
      opa_in      = opa_ff;
      opc_in      = opc_ff;
      finished_in = finished_ff;
      r0_v        = 1'b0;
      r1_v        = 1'b0;
      r0          = '0;
      r1          = '0;
      brk         = 1'b0;
      start       = 1'b0;

      b      = in_byte_ff;
      is_end = in_end_ff || (b == CH_NUL);
      if (b == CH_LF) begin
         line_n = pos_inc(line_ff);
         col_n  = '0;
      end else begin
         line_n = line_ff;
         col_n  = pos_inc(col_ff);
      end

      if (fire) begin
         if (finished_ff) begin
            r1_v = 1'b1;
            r1   = '{KIND_EOF, line_ff, col_ff, byte_ff, '0, 1'b0};
         end else if (is_end) begin
            r0_v        = flush_live;
            r0          = '{flush_kind, tok_line_ff, tok_col_ff, tok_off_ff, run_ff, 1'b0};
            r1_v        = 1'b1;
            r1          = '{KIND_EOF, line_ff, col_ff, byte_ff, '0, 1'b0};
            mode_in     = MODE_IDLE;
            finished_in = 1'b1;
         end else begin
            byte_in = pos_inc(byte_ff);
            line_in = line_n;
            col_in  = col_n;
            case (mode_ff)
               MODE_IDENT: begin
                  if (is_alpha(b) || is_digit(b) || b == CH_UNDER) begin
                     kw_in  = kw_ff & kw_match(b, run_ff);
                     run_in = len_inc(run_ff);
                  end else begin
                     brk = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(b) || (b == CH_DOT && !dot_ff)) begin
                     if (b == CH_DOT) dot_in = 1'b1;
                     run_in = len_inc(run_ff);
                  end else begin
                     brk = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (b == CH_QUOTE) begin
                     r0_v    = 1'b1;
                     r0      = '{KIND_STRING, tok_line_ff, tok_col_ff, tok_off_ff, run_ff, 1'b0};
                     mode_in = MODE_IDLE;
                  end else if (b == CH_BSLASH) begin
                     mode_in = MODE_ESCAPE;
                  end else begin
                     run_in = len_inc(run_ff);
                  end
               end
               MODE_ESCAPE: begin
                  run_in  = len_inc(run_ff);
                  mode_in = MODE_STRING;
               end
               MODE_OPER: begin
                  if (is_punct(b)) begin
                     if (run_ff == 8'd1) opc_in = b;
                     run_in = len_inc(run_ff);
                  end else begin
                     brk = 1'b1;
                  end
               end
               MODE_COMMENT: begin
                  if (b == CH_LF) brk = 1'b1;
                  else run_in = len_inc(run_ff);
               end
               default: begin
                  mode_in = MODE_IDLE;
                  start   = 1'b1;
               end
            endcase

            // emit the pending token, then treat this byte as a fresh start
            if (brk) begin
               r0_v    = 1'b1;
               r0      = '{flush_kind, tok_line_ff, tok_col_ff, tok_off_ff, run_ff, 1'b0};
               mode_in = MODE_IDLE;
               start   = 1'b1;
            end

            if (start) begin
               if (is_space(b)) begin
                  mode_in = MODE_IDLE;
               end else if (is_alpha(b) || is_digit(b) || b == CH_QUOTE ||
                            is_oper_start(b) || b == CH_HASH) begin
                  tok_line_in = line_n;
                  tok_col_in  = col_n;
                  tok_off_in  = byte_ff;
                  run_in      = 8'd1;
                  if (is_alpha(b)) begin
                     mode_in = MODE_IDENT;
                     kw_in   = kw_match(b, '0);
                  end else if (is_digit(b)) begin
                     mode_in = MODE_NUMBER;
                     dot_in  = 1'b0;
                  end else if (b == CH_QUOTE) begin
                     mode_in = MODE_STRING;
                     run_in  = '0;
                  end else if (is_oper_start(b)) begin
                     mode_in = MODE_OPER;
                     opa_in  = b;
                     opc_in  = '0;
                  end else begin
                     mode_in = MODE_COMMENT;
                  end
               end else begin
                  r1_v = 1'b1;
                  r1   = '{punct_kind(b), line_n, col_n, byte_ff, 8'd1, 1'b0};
               end
            end
         end
      end

      // mark the final token of this item
      if (r1_v) r1.last = 1'b1;
      else r0.last = 1'b1;
   end

   // pack up to two results into consecutive queue slots
   always_comb begin
      wr_a      = r0_v ? r0 : r1;
      n_push    = {1'b0, r0_v} + {1'b0, r1_v};
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(n_push);
      rd_ptr_in = rd_ptr_ff + FIFO_AW'(pop);
      count_in  = count_ff + (FIFO_AW + 1)'(n_push) - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (r0_v || r1_v) fifo_ff[wr_ptr_ff] <= wr_a;
      if (r0_v && r1_v) fifo_ff[wr_ptr_ff + 1'b1] <= r1;
      in_byte_ff  <= in_byte_in;
      in_end_ff   <= in_end_in;
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_IDLE;
         line_ff     <= POS_W'(1);
         col_ff      <= '0;
         byte_ff     <= '0;
         kw_ff       <= '1;
         finished_ff <= 1'b0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
         run_ff      <= '0;
         tok_line_ff <= POS_W'(1);
         tok_col_ff  <= '0;
         tok_off_ff  <= '0;
         dot_ff      <= 1'b0;
         opa_ff      <= '0;
         opc_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         line_ff     <= line_in;
         col_ff      <= col_in;
         byte_ff     <= byte_in;
         kw_ff       <= kw_in;
         finished_ff <= finished_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         run_ff      <= run_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         tok_off_ff  <= tok_off_in;
         dot_ff      <= dot_in;
         opa_ff      <= opa_in;
         opc_ff      <= opc_in;
      end
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_token_kind   = fifo_ff[rd_ptr_ff].kind;
   assign rsp_start_line   = fifo_ff[rd_ptr_ff].line;
   assign rsp_start_column = fifo_ff[rd_ptr_ff].column;
   assign rsp_start_offset = fifo_ff[rd_ptr_ff].offset;
   assign rsp_token_length = fifo_ff[rd_ptr_ff].length;
   assign rsp_last_result  = fifo_ff[rd_ptr_ff].last;

endmodule
